// ===== design/mfpr_pkg.sv =====
// Package for the marker framed packet receiver: request and result types,
// frame phase encoding, register indexes and reset values. No dependencies.
`default_nettype none

package mfpr_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_CHECK_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd3;

    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'h00;
    localparam logic [7:0]  RST_START_BYTE     = 8'hFF;
    localparam logic        RST_SUM_CHECK      = 1'b0;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd1000;

    localparam logic [15:0] IDLE_COUNT_MAX = 16'hFFFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_CMD   = 3'd2,
        PH_DATA1 = 3'd3,
        PH_DATA2 = 3'd4,
        PH_STOP  = 3'd5,
        PH_SUM   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       frame_done;
        logic [7:0] command;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic       link_online;
        logic       sum_error;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  start_byte;
        logic        sum_check_enable;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_sum;
        logic [7:0]  held_command;
        logic [7:0]  held_data_first;
        logic [7:0]  held_data_second;
        logic [15:0] idle_count;
        logic        online;
    } rx_state_t;

endpackage

`default_nettype wire

// ===== design/marker_framed_packet_receiver_core.sv =====
// Top level of the marker framed packet receiver: config registers, frame
// state, two-entry result buffer. Uses mfpr_pkg and mfpr_frame_step.
`default_nettype none

// Takes one request per cycle while s_ready is high (a received byte or a time
// tick) and returns exactly one registered result per request. Frame state is
// updated at acceptance, so requests can stream back to back; a two-entry
// output buffer (output register plus skid entry) keeps s_ready high for one
// more request while a result waits on m_ready. Throughput is one request
// per clock while m_ready is high. Config registers are written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while the block is idle.
module marker_framed_packet_receiver_core (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire [mfpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [mfpr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  mfpr_pkg::req_t                       s_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output mfpr_pkg::rsp_t                       m_data
);

    mfpr_pkg::cfg_t      cfg_reg;
    mfpr_pkg::rx_state_t st_reg, st_next;
    mfpr_pkg::rsp_t      rsp_next;
    mfpr_pkg::rsp_t      out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;
    logic                push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address   <= mfpr_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.start_byte       <= mfpr_pkg::RST_START_BYTE;
            cfg_reg.sum_check_enable <= mfpr_pkg::RST_SUM_CHECK;
            cfg_reg.timeout_ticks    <= mfpr_pkg::RST_TIMEOUT_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mfpr_pkg::REG_DEVICE_ADDRESS:   cfg_reg.device_address   <= cfg_wdata[7:0];
                mfpr_pkg::REG_START_BYTE:       cfg_reg.start_byte       <= cfg_wdata[7:0];
                mfpr_pkg::REG_SUM_CHECK_ENABLE: cfg_reg.sum_check_enable <= cfg_wdata[0];
                mfpr_pkg::REG_TIMEOUT_TICKS:    cfg_reg.timeout_ticks    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    mfpr_frame_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .req     (s_data),
        .st_next (st_next),
        .rsp     (rsp_next)
    );

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase            <= mfpr_pkg::PH_HUNT;
            st_reg.running_sum      <= '0;
            st_reg.held_command     <= '0;
            st_reg.held_data_first  <= '0;
            st_reg.held_data_second <= '0;
            st_reg.idle_count       <= '0;
            st_reg.online           <= 1'b0;
        end else if (push) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : rsp_next;
        end else if (push) begin
            skid_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mfpr_frame_step.sv =====
// Next-state and result logic for one request (byte or tick) of the receiver.
// Purely combinational; uses mfpr_pkg types.
`default_nettype none

module mfpr_frame_step (
    input  mfpr_pkg::cfg_t      cfg,
    input  mfpr_pkg::rx_state_t st,
    input  mfpr_pkg::req_t      req,
    output mfpr_pkg::rx_state_t st_next,
    output mfpr_pkg::rsp_t      rsp
);

    logic [7:0]  sum_add;
    logic [15:0] idle_inc;

    assign sum_add  = st.running_sum + req.rx_byte;
    assign idle_inc = (st.idle_count == mfpr_pkg::IDLE_COUNT_MAX) ?
                      st.idle_count : st.idle_count + 16'd1;

    always_comb begin
        st_next = st;
        rsp     = '0;
        if (req.opcode == mfpr_pkg::OP_TICK) begin
            st_next.idle_count = idle_inc;
            if (idle_inc > cfg.timeout_ticks) begin
                st_next.online = 1'b0;
            end
        end else begin
            unique case (st.phase)
                mfpr_pkg::PH_ADDR: begin
                    if (req.rx_byte == cfg.device_address) begin
                        st_next.running_sum = sum_add;
                        st_next.phase       = mfpr_pkg::PH_CMD;
                    end else begin
                        st_next.phase = mfpr_pkg::PH_HUNT;
                    end
                end
                mfpr_pkg::PH_CMD: begin
                    st_next.held_command = req.rx_byte;
                    st_next.running_sum  = sum_add;
                    st_next.phase        = mfpr_pkg::PH_DATA1;
                end
                mfpr_pkg::PH_DATA1: begin
                    st_next.held_data_first = req.rx_byte;
                    st_next.running_sum     = sum_add;
                    st_next.phase           = mfpr_pkg::PH_DATA2;
                end
                mfpr_pkg::PH_DATA2: begin
                    st_next.held_data_second = req.rx_byte;
                    st_next.running_sum      = sum_add;
                    st_next.phase            = mfpr_pkg::PH_STOP;
                end
                mfpr_pkg::PH_STOP: begin
                    // stop byte is summed but not checked
                    st_next.running_sum = sum_add;
                    st_next.phase       = mfpr_pkg::PH_SUM;
                end
                mfpr_pkg::PH_SUM: begin
                    st_next.phase = mfpr_pkg::PH_HUNT;
                    if (cfg.sum_check_enable && (req.rx_byte != st.running_sum)) begin
                        rsp.sum_error = 1'b1;
                    end else begin
                        rsp.frame_done     = 1'b1;
                        rsp.command        = st.held_command;
                        rsp.data_first     = st.held_data_first;
                        rsp.data_second    = st.held_data_second;
                        st_next.idle_count = '0;
                        st_next.online     = 1'b1;
                    end
                end
                default: begin
                    st_next.phase = mfpr_pkg::PH_HUNT;
                    if (req.rx_byte == cfg.start_byte) begin
                        st_next.running_sum = req.rx_byte;
                        st_next.phase       = mfpr_pkg::PH_ADDR;
                    end
                end
            endcase
        end
        rsp.link_online = st_next.online;
    end

endmodule

`default_nettype wire
